/* hw/rtl/kcl_pkg.sv */
// kcl_pkg: shared constants and the result type of the keypad code lock.
// No dependencies; compiled first.
`default_nettype none

package kcl_pkg;

    localparam int unsigned KEY_COUNT = 6;
    localparam int unsigned CODE_LEN  = 4;
    localparam int unsigned DIGIT_W   = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_THIRD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_KEY_FOURTH = 2'd3;

    localparam logic [DIGIT_W-1:0] CODE_RESET_FIRST  = 3'd1;
    localparam logic [DIGIT_W-1:0] CODE_RESET_SECOND = 3'd2;
    localparam logic [DIGIT_W-1:0] CODE_RESET_THIRD  = 3'd3;
    localparam logic [DIGIT_W-1:0] CODE_RESET_FOURTH = 3'd4;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic [1:0] digits_held;
        logic       attempt_done;
        logic       attempt_match;
        logic       lock_open;
        digit_t     shown_first;
        digit_t     shown_second;
        digit_t     shown_third;
        digit_t     shown_fourth;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/kcl_key_if.sv */
// kcl_key_if: valid/ready channel carrying one keypad scan per beat.
// No dependencies.
`default_nettype none

interface kcl_key_if;
    logic       valid;
    logic       ready;
    logic [5:0] pressed_keys;

    modport source (output valid, output pressed_keys, input ready);
    modport sink   (input valid, input pressed_keys, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kcl_result_if.sv */
// kcl_result_if: valid/ready channel carrying one lock result per beat.
// No dependencies.
`default_nettype none

interface kcl_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] digits_held;
    logic       attempt_done;
    logic       attempt_match;
    logic       lock_open;
    logic [2:0] shown_first;
    logic [2:0] shown_second;
    logic [2:0] shown_third;
    logic [2:0] shown_fourth;

    modport source (output valid, output digits_held, output attempt_done,
                    output attempt_match, output lock_open, output shown_first,
                    output shown_second, output shown_third, output shown_fourth,
                    input ready);
    modport sink   (input valid, input digits_held, input attempt_done,
                    input attempt_match, input lock_open, input shown_first,
                    input shown_second, input shown_third, input shown_fourth,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/keypad_code_lock_unit.sv */
// keypad_code_lock_unit: four-digit code lock fed by 2x3 keypad scans.
// Depends on kcl_pkg, kcl_key_if and kcl_result_if.
//
// Usage:
//   keys   : one beat per full matrix scan, bit row*3+col set while pressed.
//   result : one beat per scan with the digits held, attempt flags, the
//            latched lock state and the four shown digits.
//   cfg_*  : write enable, register index 0..3 and a 3-bit code digit;
//            write only while no scan is in flight.
// Result: each scan's result is registered into the result buffer.
// Throughput: one scan per cycle unless stalled; the edge detect, append
//   and compare all sit between the state registers and the result buffer.
// Stall: the result buffer holds two beats; keys.ready drops only when
//   both are full, so one scan is still taken while a result waits.
// Reset: previous scan released, entry empty, lock closed, code 1-2-3-4,
//   result buffer empty.
`default_nettype none

module keypad_code_lock_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [2:0] cfg_data,
    kcl_key_if.sink         keys,
    kcl_result_if.source    result
);

    kcl_pkg::digit_t        code_reg [kcl_pkg::CODE_LEN];
    logic [5:0]             prev_scan_reg;
    logic [1:0]             count_reg;
    kcl_pkg::digit_t        digits_reg [3];
    logic                   unlocked_reg;

    logic [1:0]             count_next;
    kcl_pkg::digit_t        digits_next [3];
    logic                   unlocked_next;

    kcl_pkg::result_t       res_new;
    kcl_pkg::result_t       head_reg;
    kcl_pkg::result_t       skid_reg;
    logic                   head_valid_reg;
    logic                   skid_valid_reg;

    logic                   push;
    logic                   pop;

    logic [5:0]             rising;
    logic [2:0]             cnt;
    kcl_pkg::digit_t        d [kcl_pkg::CODE_LEN];
    kcl_pkg::digit_t        shown [kcl_pkg::CODE_LEN];
    logic                   done;
    logic                   match;

    assign keys.ready   = !skid_valid_reg;
    assign push         = keys.valid && keys.ready;
    assign pop          = head_valid_reg && result.ready;

    always_comb
    begin
        rising = keys.pressed_keys & ~prev_scan_reg;
        cnt    = {1'b0, count_reg};
        d[0]   = digits_reg[0];
        d[1]   = digits_reg[1];
        d[2]   = digits_reg[2];
        d[3]   = '0;
        for (int k = 0; k < kcl_pkg::KEY_COUNT; k++)
        begin
            if (rising[k] && !unlocked_reg && cnt < 3'd4)
            begin
                d[cnt[1:0]] = 3'(k + 1);
                cnt         = cnt + 3'd1;
            end
        end
        for (int i = 0; i < kcl_pkg::CODE_LEN; i++)
        begin
            shown[i] = (cnt > 3'(i)) ? d[i] : '0;
        end
        done  = (cnt == 3'd4);
        match = done && (d[0] == code_reg[0]) && (d[1] == code_reg[1])
                     && (d[2] == code_reg[2]) && (d[3] == code_reg[3]);

        count_next    = done ? 2'd0 : cnt[1:0];
        unlocked_next = unlocked_reg || match;
        for (int i = 0; i < 3; i++)
        begin
            digits_next[i] = done ? '0 : shown[i];
        end

        res_new.digits_held   = count_next;
        res_new.attempt_done  = done;
        res_new.attempt_match = match;
        res_new.lock_open     = unlocked_next;
        res_new.shown_first   = shown[0];
        res_new.shown_second  = shown[1];
        res_new.shown_third   = shown[2];
        res_new.shown_fourth  = shown[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg[0]   <= kcl_pkg::CODE_RESET_FIRST;
            code_reg[1]   <= kcl_pkg::CODE_RESET_SECOND;
            code_reg[2]   <= kcl_pkg::CODE_RESET_THIRD;
            code_reg[3]   <= kcl_pkg::CODE_RESET_FOURTH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                kcl_pkg::REG_CODE_KEY_FIRST:  code_reg[0] <= cfg_data;
                kcl_pkg::REG_CODE_KEY_SECOND: code_reg[1] <= cfg_data;
                kcl_pkg::REG_CODE_KEY_THIRD:  code_reg[2] <= cfg_data;
                kcl_pkg::REG_CODE_KEY_FOURTH: code_reg[3] <= cfg_data;
                default:                      code_reg[0] <= code_reg[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_scan_reg <= '0;
            count_reg     <= '0;
            digits_reg[0] <= '0;
            digits_reg[1] <= '0;
            digits_reg[2] <= '0;
            unlocked_reg  <= 1'b0;
        end
        else if (push)
        begin
            prev_scan_reg <= keys.pressed_keys;
            count_reg     <= count_next;
            digits_reg[0] <= digits_next[0];
            digits_reg[1] <= digits_next[1];
            digits_reg[2] <= digits_next[2];
            unlocked_reg  <= unlocked_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            case ({push, pop})
                2'b10:
                begin
                    if (!head_valid_reg)
                        head_valid_reg <= 1'b1;
                    else
                        skid_valid_reg <= 1'b1;
                end
                2'b01:
                begin
                    if (skid_valid_reg)
                        skid_valid_reg <= 1'b0;
                    else
                        head_valid_reg <= 1'b0;
                end
                default:
                begin
                    head_valid_reg <= head_valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (!head_valid_reg)
                    head_reg <= res_new;
                else
                    skid_reg <= res_new;
            end
            2'b01:
            begin
                if (skid_valid_reg)
                    head_reg <= skid_reg;
            end
            2'b11:
            begin
                if (skid_valid_reg)
                begin
                    head_reg <= skid_reg;
                    skid_reg <= res_new;
                end
                else
                begin
                    head_reg <= res_new;
                end
            end
            default:
            begin
                head_reg <= head_reg;
            end
        endcase
    end

    assign result.valid         = head_valid_reg;
    assign result.digits_held   = head_reg.digits_held;
    assign result.attempt_done  = head_reg.attempt_done;
    assign result.attempt_match = head_reg.attempt_match;
    assign result.lock_open     = head_reg.lock_open;
    assign result.shown_first   = head_reg.shown_first;
    assign result.shown_second  = head_reg.shown_second;
    assign result.shown_third   = head_reg.shown_third;
    assign result.shown_fourth  = head_reg.shown_fourth;

endmodule

`default_nettype wire
